[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion sampled on the rising clock edge, off during reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that holds during reset as well
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/hcb_pkg.sv]
// shared types and constants for the huffman code builder
// no dependencies
`default_nettype none
package hcb_pkg;
  localparam int SYM_W  = 8;
  localparam int WIN_W  = 16;
  localparam int CODE_W = 63;
  localparam int LEN_W  = 6;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [WIN_W-1:0] weight;
    logic             final_entry;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0]  out_symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              last_code;
  } out_item_t;
endpackage
`default_nettype wire

[rtl/hcb_stream_if.sv]
// valid/ready channel interface carrying one payload struct
// no dependencies
`default_nettype none
interface hcb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/huffman_code_builder.sv]
// huffman code builder top level: load, merge sequencer, code walk
// depends on hcb_pkg, hcb_stream_if, hcb_min_unit
//
// load: one cycle per input transfer, ready only while loading
// build: n-1 merges, each a right-child scan, a left-child scan and then an update
// walk: a WALK state and a STEP state per tree level (registered node table read); a code is
//   valid once its walk reaches the root, and it holds while the output stalls
// ready again right after the last code transfer; reset (synchronous, active low) clears
//   count and sequencer
`default_nettype none
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = 32,
  parameter int WEIGHT_BITS = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  hcb_stream_if.sink   in_ch,
  hcb_stream_if.source out_ch
);
  import hcb_pkg::*;

  localparam int NODES = 2 * MAX_SYMBOLS;
  localparam int IX_W  = $clog2(NODES);
  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int SW_W  = WEIGHT_BITS + $clog2(MAX_SYMBOLS) + 1;

  typedef enum logic [2:0] {
    S_LOAD, S_SCAN_R, S_SCAN_L, S_MERGE, S_WALK, S_STEP, S_EMIT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  scan_r;     // slot scan index, one past the end marks done
  logic [CNT_W-1:0]  merges_r;
  logic [IX_W-1:0]   next_node_r, root_r, right_r;
  logic [CNT_W-1:0]  sym_r;      // symbol being emitted
  logic [IX_W-1:0]   node_r;     // walk position
  logic [CODE_W-1:0] bits_r;
  logic [LEN_W-1:0]  len_r;
  logic [IX_W-1:0]   par_rd_r;   // registered node table read
  logic              side_rd_r;

  // stores; none of them needs a reset
  logic [SYM_W-1:0]  sym_mem   [MAX_SYMBOLS];
  logic [SW_W-1:0]   slot_w    [MAX_SYMBOLS];
  logic [IX_W-1:0]   slot_n    [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] used_r;
  logic [IX_W-1:0]   parent_m  [NODES];
  logic              side_m    [NODES];

  logic [SW_W-1:0]   wmask;
  logic              scan_go, scan_done, cand_ok;
  logic [IX_W-1:0]   mu_pick, left_ix;
  logic [CNT_W-1:0]  slot_ix;
  logic              out_valid_r;
  out_item_t         out_r;
  logic              set_end;

  assign wmask     = SW_W'((64'd1 << WEIGHT_BITS) - 64'd1);
  assign slot_ix   = scan_r;
  assign scan_done = (scan_r == count_r);
  assign scan_go   = (state_r == S_SCAN_R || state_r == S_SCAN_L) && !scan_done;
  assign cand_ok   = scan_go && !used_r[slot_ix[$clog2(MAX_SYMBOLS > 1 ? MAX_SYMBOLS : 2)-1:0]];

  hcb_min_unit #(.SW_W(SW_W), .IX_W(IX_W)) u_min (
    .clk    (clk),
    .start  (scan_go && scan_r == '0),
    .cand_ok(cand_ok),
    .cand_w (slot_w[slot_ix[$clog2(MAX_SYMBOLS > 1 ? MAX_SYMBOLS : 2)-1:0]]),
    .cand_ix(IX_W'(slot_ix)),
    .pick_ix(mu_pick)
  );
  assign left_ix = mu_pick;

  assign in_ch.ready  = (state_r == S_LOAD);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign set_end = in_ch.data.final_entry || (count_r == CNT_W'(MAX_SYMBOLS - 1));

  localparam int SL_W = $clog2(MAX_SYMBOLS > 1 ? MAX_SYMBOLS : 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      root_r      <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_ch.valid) begin
            // load transfer into the next slot
            sym_mem[count_r[SL_W-1:0]] <= in_ch.data.symbol;
            slot_w[count_r[SL_W-1:0]]  <= SW_W'(in_ch.data.weight) & wmask;
            slot_n[count_r[SL_W-1:0]]  <= IX_W'(count_r);
            used_r[count_r[SL_W-1:0]]  <= 1'b0;
            count_r <= count_r + 1'b1;
            if (set_end) begin
              next_node_r <= IX_W'(count_r + 1'b1);
              merges_r    <= CNT_W'(1);
              scan_r      <= '0;
              root_r      <= '0;
              state_r     <= (count_r == '0) ? S_WALK : S_SCAN_R;
              sym_r       <= '0;
              node_r      <= '0;
              bits_r      <= '0;
              len_r       <= '0;
            end
          end
        end
        S_SCAN_R: begin
          if (scan_done) begin
            right_r <= mu_pick;
            used_r[mu_pick[SL_W-1:0]] <= 1'b1;
            scan_r  <= '0;
            state_r <= S_SCAN_L;
          end else scan_r <= scan_r + 1'b1;
        end
        S_SCAN_L: begin
          if (scan_done) state_r <= S_MERGE;
          else scan_r <= scan_r + 1'b1;
        end
        S_MERGE: begin
          // both children hang under the new node, which takes the left slot
          parent_m[slot_n[right_r[SL_W-1:0]]] <= next_node_r;
          side_m[slot_n[right_r[SL_W-1:0]]]   <= 1'b1;
          parent_m[slot_n[left_ix[SL_W-1:0]]] <= next_node_r;
          side_m[slot_n[left_ix[SL_W-1:0]]]   <= 1'b0;
          slot_w[left_ix[SL_W-1:0]] <= slot_w[left_ix[SL_W-1:0]]
                                       + slot_w[right_r[SL_W-1:0]];
          slot_n[left_ix[SL_W-1:0]] <= next_node_r;
          next_node_r <= next_node_r + 1'b1;
          scan_r <= '0;
          if (merges_r + 1'b1 == count_r) begin
            root_r  <= next_node_r;
            state_r <= S_WALK;
          end else begin
            merges_r <= merges_r + 1'b1;
            state_r  <= S_SCAN_R;
          end
        end
        S_WALK: begin
          // check for the root or a full-length code, else fetch this node's parent and side
          if (node_r == root_r || len_r == LEN_W'(CODE_W)) begin
            out_r.out_symbol  <= sym_mem[sym_r[SL_W-1:0]];
            out_r.code_bits   <= bits_r;
            out_r.code_length <= len_r;
            out_r.last_code   <= (sym_r + 1'b1 == count_r);
            out_valid_r       <= 1'b1;
            state_r           <= S_EMIT;
          end else begin
            par_rd_r  <= parent_m[node_r];
            side_rd_r <= side_m[node_r];
            state_r   <= S_STEP;
          end
        end
        S_STEP: begin
          // one tree level toward the root
          bits_r  <= bits_r | (CODE_W'(side_rd_r) << len_r);
          len_r   <= len_r + 1'b1;
          node_r  <= par_rd_r;
          state_r <= S_WALK;
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            bits_r <= '0;
            len_r  <= '0;
            if (sym_r + 1'b1 == count_r) begin
              count_r <= '0;
              used_r  <= '0;
              state_r <= S_LOAD;
            end else begin
              sym_r   <= sym_r + 1'b1;
              node_r  <= IX_W'(sym_r + 1'b1);
              state_r <= S_WALK;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/hcb_min_unit.sv]
// shared compare unit: one slot per cycle against the running minimum
// depends on hcb_pkg
`default_nettype none
module hcb_min_unit #(
  parameter int SW_W = 22,
  parameter int IX_W = 6
) (
  input  wire logic            clk,
  input  wire logic            start,
  input  wire logic            cand_ok,
  input  wire logic [SW_W-1:0] cand_w,
  input  wire logic [IX_W-1:0] cand_ix,
  output logic      [IX_W-1:0] pick_ix
);
  import hcb_pkg::*;
  logic [SW_W-1:0] best_w_r;
  logic            found_r;
  logic [IX_W-1:0] pick_r;
  logic            take;

  // strict less keeps the lowest index on ties
  assign take = cand_ok && (!(found_r && !start) || cand_w < best_w_r);

  always_ff @(posedge clk) begin
    if (start) found_r <= 1'b0;
    if (take) begin
      best_w_r <= cand_w;
      pick_r   <= cand_ix;
      found_r  <= 1'b1;
    end
  end
  assign pick_ix = pick_r;
endmodule
`default_nettype wire

[rtl/hcb_checker.sv]
// port-level checker for the huffman code builder, bound to the top level
// depends on hcb_pkg, assert_macros.svh
`include "assert_macros.svh"
`default_nettype none
module hcb_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire hcb_pkg::out_item_t out_data
);
  import hcb_pkg::*;
  // never accepts input while a code waits
  `ASSERT_CLK(a_no_overlap, clk, rst_n, !(out_valid && in_ready), "input ready during output")
  // stalled code holds
  `ASSERT_CLK(a_hold, clk, rst_n, out_valid && !out_ready |=> $stable(out_data), "output changed")
  // code length never past the word
  `ASSERT_CLK(a_len, clk, rst_n, out_valid |-> out_data.code_length <= LEN_W'(CODE_W), "bad length")
  // reset leaves no output pending
  `ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_valid, "valid after reset")
endmodule
bind huffman_code_builder hcb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
